// ----- rtl/pspc_pkg.sv -----
package pspc_pkg;

    localparam int SPEED_BITS = 8;

    localparam int KPH_Q16 = 105470;
    localparam int SPD_W   = SPEED_BITS + 9;
    localparam int ERR_W   = SPEED_BITS + 10;
    localparam int ESUM_W  = ERR_W + 1;

    localparam int MA_W    = 25;
    localparam int MB_W    = 18;
    localparam int MP_W    = MA_W + MB_W;
    localparam int CHUNK_W = 24;

    localparam int INT_W   = 48;
    localparam int ACC_W   = 66;
    localparam int STEP_SH = 17;
    localparam int STEP_W  = MP_W + 1 - STEP_SH;

    localparam int SP_SH   = 16 - SPEED_BITS;
    localparam int MS_SH   = 24 - SPEED_BITS;
    localparam int RS_DN   = (SPEED_BITS > 8) ? SPEED_BITS - 8 : 0;
    localparam int RS_UP   = (SPEED_BITS < 8) ? 8 - SPEED_BITS : 0;
    localparam int RS_RND  = (RS_DN > 0) ? RS_DN - 1 : 0;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(1) << 50;
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;
    localparam logic signed [ACC_W-1:0] PWR_MIN = -(ACC_W'(1) << (INT_W - 1));

    localparam logic [1:0] OP_RAISE  = 2'd0;
    localparam logic [1:0] OP_LOWER  = 2'd1;
    localparam logic [1:0] OP_EBRAKE = 2'd2;
    localparam logic [1:0] OP_SBRAKE = 2'd3;

    localparam logic [1:0] CFG_KP    = 2'd0;
    localparam logic [1:0] CFG_KI    = 2'd1;
    localparam logic [1:0] CFG_T     = 2'd2;
    localparam logic [1:0] CFG_LIMIT = 2'd3;

    localparam logic [15:0] T_RESET     = 16'd6554;
    localparam logic [31:0] LIMIT_RESET = 32'd120000;

endpackage

// ----- rtl/pi_speed_power_controller_unit.sv -----
// Channel   Dir  Word                                               Accept
// s_axis    in   tdata: measured_speed; tuser: operation            tvalid & tready
// m_axis    out  tdata: power, setpoint, e-brake, s-brake; tuser    tvalid & tready
// cfg       in   i_cfg_index / i_cfg_data                           i_cfg_we
//
// One 25x18 signed multiplier and one 66-bit accumulator are stepped by the
// sequencer through accept, nine work steps and result load for each word;
// lowering a zero setpoint skips to result load. Input is taken only in idle.
// The result register lets a new word be accepted while the last result waits;
// the finish step holds until that register is free. Sync active-low reset.
module pi_speed_power_controller_unit
    import pspc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] measured_speed
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [47:0] commanded_power, [55:48] setpoint_speed, [56] emergency_brake,
    // [57] service_brake, [63:58] zero
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] power_clamped
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MSP   = 4'd1;
    localparam logic [3:0] ST_MMS   = 4'd2;
    localparam logic [3:0] ST_ERR   = 4'd3;
    localparam logic [3:0] ST_MESUM = 4'd4;
    localparam logic [3:0] ST_MKP   = 4'd5;
    localparam logic [3:0] ST_MKILO = 4'd6;
    localparam logic [3:0] ST_MKIHI = 4'd7;
    localparam logic [3:0] ST_ACCHI = 4'd8;
    localparam logic [3:0] ST_SCALE = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [15:0] r_kp;
    logic [15:0] r_ki;
    logic [15:0] r_t;
    logic [31:0] r_lim;

    logic [3:0]  r_state;
    logic [7:0]  r_setpoint;
    logic        r_ebrake;
    logic        r_sbrake;
    logic        r_skip;
    logic [15:0] r_meas;

    logic signed [ERR_W-1:0] r_prev;
    logic signed [INT_W-1:0] r_integ;
    logic signed [INT_W-1:0] r_last;

    logic signed [MP_W-1:0]  r_prod;
    logic [SPD_W-1:0]        r_spk;
    logic signed [ERR_W-1:0] r_err;
    logic signed [INT_W-1:0] r_uk;
    logic signed [ACC_W-1:0] r_acc;

    logic        r_m_valid;
    logic [63:0] r_m_data;
    logic        r_m_user;

    logic signed [MA_W-1:0]   w_ma;
    logic signed [MB_W-1:0]   w_mb;
    logic signed [MP_W-1:0]   w_prod;
    logic signed [ESUM_W-1:0] w_esum;
    logic [MP_W-1:0]          w_sp_rnd;
    logic [MP_W-1:0]          w_ms_rnd;
    logic [SPD_W-1:0]         w_spk;
    logic [SPD_W-1:0]         w_msk;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [MP_W:0]     w_step_sum;
    logic signed [STEP_W-1:0] w_step;
    logic signed [INT_W:0]    w_uk_sum;
    logic signed [INT_W-1:0]  w_uk;
    logic signed [ACC_W-1:0]  w_scaled;
    logic signed [ACC_W-1:0]  w_lim;
    logic                     w_clamp;
    logic signed [INT_W-1:0]  w_power;
    logic                     w_out_free;
    logic                     w_skip;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_skip        = (s_axis_tuser == OP_LOWER) && (r_setpoint == 8'd0);

    // shared multiplier operand select
    assign w_esum = ESUM_W'(r_err) + ESUM_W'(r_prev);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_MSP: begin
                w_ma = $signed(MA_W'(r_setpoint));
                w_mb = $signed(MB_W'(KPH_Q16));
            end
            ST_MMS: begin
                w_ma = $signed(MA_W'(r_meas));
                w_mb = $signed(MB_W'(KPH_Q16));
            end
            ST_MESUM: begin
                w_ma = MA_W'(w_esum);
                w_mb = $signed(MB_W'(r_t));
            end
            ST_MKP: begin
                w_ma = MA_W'(r_err);
                w_mb = $signed(MB_W'(r_kp));
            end
            ST_MKILO: begin
                w_ma = $signed({1'b0, r_uk[CHUNK_W-1:0]});
                w_mb = $signed(MB_W'(r_ki));
            end
            ST_MKIHI: begin
                w_ma = $signed({r_uk[INT_W-1], r_uk[INT_W-1:CHUNK_W]});
                w_mb = $signed(MB_W'(r_ki));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // speed conversion rounding, half up
    assign w_sp_rnd = $unsigned(r_prod) + (MP_W'(1) << (SP_SH - 1));
    assign w_ms_rnd = $unsigned(r_prod) + (MP_W'(1) << (MS_SH - 1));
    assign w_spk    = SPD_W'(w_sp_rnd >> SP_SH);
    assign w_msk    = SPD_W'(w_ms_rnd >> MS_SH);
    assign w_err    = $signed({1'b0, r_spk}) - $signed({1'b0, w_msk});

    // trapezoid step and saturating integrator update
    assign w_step_sum = (MP_W + 1)'(r_prod) + $signed((MP_W + 1)'(1) << (STEP_SH - 1));
    assign w_step     = STEP_W'(w_step_sum >>> STEP_SH);
    assign w_uk_sum   = (INT_W + 1)'(r_integ) + (INT_W + 1)'(w_step);

    always_comb begin
        w_uk = w_uk_sum[INT_W-1:0];
        if (w_uk_sum[INT_W] != w_uk_sum[INT_W-1]) begin
            w_uk = w_uk_sum[INT_W] ? {1'b1, {(INT_W - 1){1'b0}}}
                                   : {1'b0, {(INT_W - 1){1'b1}}};
        end
    end

    // bring the power sum to Q.8
    always_comb begin
        w_scaled = r_acc;
        if (RS_DN > 0) begin
            w_scaled = (r_acc + $signed(ACC_W'(1) << RS_RND)) >>> RS_DN;
        end else if (RS_UP > 0) begin
            if (r_acc > SAT_HI) begin
                w_scaled = SAT_HI <<< RS_UP;
            end else if (r_acc < SAT_LO) begin
                w_scaled = SAT_LO <<< RS_UP;
            end else begin
                w_scaled = r_acc <<< RS_UP;
            end
        end
    end

    // output clamp
    assign w_lim = $signed({{(ACC_W - 40){1'b0}}, r_lim, 8'b0});

    always_comb begin
        w_clamp = 1'b0;
        w_power = r_acc[INT_W-1:0];
        if (r_skip) begin
            w_power = r_last;
        end else if (r_acc > w_lim) begin
            w_clamp = 1'b1;
            w_power = w_lim[INT_W-1:0];
        end else if (r_acc < PWR_MIN) begin
            w_power = PWR_MIN[INT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
            r_ki <= '0;
            r_t  <= T_RESET;
            r_lim <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KP:    r_kp  <= i_cfg_data[15:0];
                CFG_KI:    r_ki  <= i_cfg_data[15:0];
                CFG_T:     r_t   <= i_cfg_data[15:0];
                CFG_LIMIT: r_lim <= i_cfg_data;
                default:   r_lim <= r_lim;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_setpoint <= '0;
            r_ebrake   <= 1'b0;
            r_sbrake   <= 1'b0;
            r_skip     <= 1'b0;
            r_prev     <= '0;
            r_integ    <= '0;
            r_last     <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready && (r_state != ST_DONE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_meas  <= s_axis_tdata;
                        r_skip  <= w_skip;
                        r_state <= w_skip ? ST_DONE : ST_MSP;
                        case (s_axis_tuser)
                            OP_RAISE: begin
                                if (r_setpoint != 8'hFF) begin
                                    r_setpoint <= r_setpoint + 8'd1;
                                end
                            end
                            OP_LOWER: begin
                                if (r_setpoint != 8'd0) begin
                                    r_setpoint <= r_setpoint - 8'd1;
                                end
                            end
                            OP_EBRAKE: begin
                                r_ebrake   <= 1'b1;
                                r_setpoint <= '0;
                            end
                            default: begin
                                r_sbrake   <= 1'b1;
                                r_setpoint <= '0;
                            end
                        endcase
                    end
                end
                ST_MSP: begin
                    r_prod  <= w_prod;
                    r_state <= ST_MMS;
                end
                ST_MMS: begin
                    r_spk   <= w_spk;
                    r_prod  <= w_prod;
                    r_state <= ST_ERR;
                end
                ST_ERR: begin
                    r_err   <= w_err;
                    r_state <= ST_MESUM;
                end
                ST_MESUM: begin
                    r_prod  <= w_prod;
                    r_state <= ST_MKP;
                end
                ST_MKP: begin
                    r_uk    <= w_uk;
                    r_prod  <= w_prod;
                    r_state <= ST_MKILO;
                end
                ST_MKILO: begin
                    r_acc   <= ACC_W'(r_prod);
                    r_prod  <= w_prod;
                    r_state <= ST_MKIHI;
                end
                ST_MKIHI: begin
                    r_acc   <= r_acc + ACC_W'(r_prod);
                    r_prod  <= w_prod;
                    r_state <= ST_ACCHI;
                end
                ST_ACCHI: begin
                    r_acc   <= r_acc + (ACC_W'(r_prod) <<< CHUNK_W);
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_acc   <= w_scaled;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {6'b0, r_sbrake, r_ebrake, r_setpoint, w_power};
                        r_m_user  <= w_clamp;
                        if (!r_skip) begin
                            r_prev <= r_err;
                            r_last <= w_power;
                            if (!w_clamp) begin
                                r_integ <= r_uk;
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
